>>> sv/pixel_control_packet_merger_core_defines.svh
// Assertion macros shared by the checker of the packet merger core.
// Depends on nothing; the enclosing scope must provide clk and arst_n.
`ifndef PIXEL_CONTROL_PACKET_MERGER_CORE_DEFINES_SVH
`define PIXEL_CONTROL_PACKET_MERGER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PCPM_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PCPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/pcpm_pkg.sv
// Shared sizes, codes and interface types of the packet merger core.
// Depends on nothing; every module file refers to it by scoped names.
package pcpm_pkg;

	localparam int CHANNELS         = 4;
	localparam int LEDS_PER_CHANNEL = 682;
	localparam int SLICE_BYTES      = LEDS_PER_CHANNEL * 3;
	localparam int STORE_BYTES      = CHANNELS * SLICE_BYTES;
	localparam int ADDR_W           = $clog2(STORE_BYTES);
	localparam int WADDR_W          = 24;
	localparam int IDX_W            = 13;
	localparam int HDR_BYTES        = 4;
	localparam logic [15:0] FRAME_SIZE16 = 16'(STORE_BYTES & 32'h0000_FFFF);

	localparam logic [7:0] CMD_SET_PIXELS = 8'd0;

	localparam int HP_W = 3;
	localparam logic [HP_W-1:0] HP_CHAN    = 3'd0;
	localparam logic [HP_W-1:0] HP_CMD     = 3'd1;
	localparam logic [HP_W-1:0] HP_LEN_HI  = 3'd2;
	localparam logic [HP_W-1:0] HP_LEN_LO  = 3'd3;
	localparam logic [HP_W-1:0] HP_PAYLOAD = 3'd4;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		MODE_STREAM = 2'd0,
		MODE_READ   = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_STORED   = 3'd1,
		EV_BAD_CHAN = 3'd2,
		EV_BAD_LEN  = 3'd3,
		EV_BAD_CMD  = 3'd4
	} event_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       frame_dirty;
		logic [2:0] packet_event;
	} result_t;

endpackage

>>> sv/pcpm_parser.sv
// Packet header parser, payload write address generation and dirty flag.
// Depends on pcpm_pkg.
module pcpm_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [1:0]        mode,
	input  logic [7:0]        byte_in,
	output pcpm_pkg::wr_req_t wr,
	output logic [2:0]        packet_event,
	output logic              dirty_next
);

	logic [pcpm_pkg::HP_W-1:0] hp_q, hp_n;
	logic [7:0]                chan_q, chan_n;
	logic [7:0]                cmd_q, cmd_n;
	logic [15:0]               len_q, len_n;
	logic [15:0]               pos_q, pos_n;
	logic                      acc_q, acc_n;
	logic                      dirty_q, dirty_n;
	logic [pcpm_pkg::WADDR_W-1:0] addr_full;
	pcpm_pkg::event_t          ev;

	assign addr_full = pcpm_pkg::WADDR_W'(chan_q) * pcpm_pkg::WADDR_W'(pcpm_pkg::SLICE_BYTES)
		+ pcpm_pkg::WADDR_W'(pos_q);

	always_comb begin
		hp_n    = hp_q;
		chan_n  = chan_q;
		cmd_n   = cmd_q;
		len_n   = len_q;
		pos_n   = pos_q;
		acc_n   = acc_q;
		dirty_n = dirty_q;
		ev      = pcpm_pkg::EV_NONE;
		wr.en   = 1'b0;
		wr.addr = addr_full[pcpm_pkg::ADDR_W-1:0];
		wr.data = byte_in;
		if (item_valid) begin
			case (pcpm_pkg::mode_t'(mode))
				pcpm_pkg::MODE_STREAM: begin
					if (hp_q < pcpm_pkg::HP_PAYLOAD) begin
						case (hp_q)
							pcpm_pkg::HP_CHAN:   chan_n = byte_in;
							pcpm_pkg::HP_CMD:    cmd_n = byte_in;
							pcpm_pkg::HP_LEN_HI: len_n = {byte_in, 8'h00};
							default:             len_n = len_q | {8'h00, byte_in};
						endcase
						hp_n = hp_q + 3'd1;
						if (hp_n == pcpm_pkg::HP_PAYLOAD) begin
							pos_n = '0;
							acc_n = 1'b0;
							if (cmd_n != pcpm_pkg::CMD_SET_PIXELS) begin
								ev = pcpm_pkg::EV_BAD_CMD;
							end else if (chan_n >= 8'(pcpm_pkg::CHANNELS)) begin
								ev = pcpm_pkg::EV_BAD_CHAN;
							end else if (len_n > 16'(pcpm_pkg::SLICE_BYTES)) begin
								ev = pcpm_pkg::EV_BAD_LEN;
							end else begin
								acc_n = 1'b1;
							end
							if (len_n == 16'd0) begin
								hp_n = pcpm_pkg::HP_CHAN;
								if (acc_n) begin
									dirty_n = 1'b1;
									ev      = pcpm_pkg::EV_STORED;
								end
								acc_n = 1'b0;
							end
						end
					end else begin
						wr.en = acc_q && (addr_full < pcpm_pkg::WADDR_W'(pcpm_pkg::STORE_BYTES));
						pos_n = pos_q + 16'd1;
						if (pos_n >= len_q) begin
							hp_n = pcpm_pkg::HP_CHAN;
							if (acc_q) begin
								dirty_n = 1'b1;
								ev      = pcpm_pkg::EV_STORED;
							end
							acc_n = 1'b0;
						end
					end
				end
				pcpm_pkg::MODE_CLEAR: dirty_n = 1'b0;
				default: ;
			endcase
		end
	end

	assign packet_event = ev;
	assign dirty_next   = dirty_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q    <= pcpm_pkg::HP_CHAN;
			chan_q  <= '0;
			cmd_q   <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			acc_q   <= 1'b0;
			dirty_q <= 1'b0;
		end else begin
			hp_q    <= hp_n;
			chan_q  <= chan_n;
			cmd_q   <= cmd_n;
			len_q   <= len_n;
			pos_q   <= pos_n;
			acc_q   <= acc_n;
			dirty_q <= dirty_n;
		end
	end

endmodule

>>> sv/pcpm_store.sv
// LED byte store with one write and one registered read port per cycle,
// plus the zero-fill sweep that runs after reset. Depends on pcpm_pkg.
module pcpm_store (
	input  logic              clk,
	input  logic              arst_n,
	input  pcpm_pkg::wr_req_t wr,
	input  pcpm_pkg::rd_req_t rd,
	output logic [7:0]        rdata,
	output logic              clearing
);

	logic [7:0]                mem_q [pcpm_pkg::STORE_BYTES];
	logic [7:0]                rdata_q;
	logic                      clearing_q;
	logic [pcpm_pkg::ADDR_W-1:0] clr_idx_q;
	logic                      we;
	logic [pcpm_pkg::ADDR_W-1:0] waddr;
	logic [7:0]                wdata;

	assign we    = clearing_q || wr.en;
	assign waddr = clearing_q ? clr_idx_q : wr.addr;
	assign wdata = clearing_q ? 8'h00 : wr.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == pcpm_pkg::ADDR_W'(pcpm_pkg::STORE_BYTES - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd.en) begin
			rdata_q <= mem_q[rd.addr];
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule

>>> sv/pcpm_out_queue.sv
// Four-entry result queue that decouples the output handshake from the
// pipeline. Depends on pcpm_pkg.
module pcpm_out_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  pcpm_pkg::result_t           push_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output pcpm_pkg::result_t           head,
	output logic [pcpm_pkg::QCNT_W-1:0] count
);

	pcpm_pkg::result_t                 entry_q [pcpm_pkg::QDEPTH];
	logic [pcpm_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [pcpm_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [pcpm_pkg::QCNT_W-1:0]       count_q;
	logic                              pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign head      = entry_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> sv/pixel_control_packet_merger_core.sv
// Pixel-control packet merger: takes one word per clock while in_ready is high,
// either a stream byte, a frame read, a dirty clear or a word of the unused mode,
// and returns one result word for each, through the s1 and s2 stage registers
// and the result queue; the rate is set by the parser and the one-write, one-read
// LED store. After reset the store is zero-filled one byte per cycle, during
// which in_ready stays low. Results wait in a four-entry queue; in_ready falls
// once four words are held by the pipeline and the queue together.
// Depends on pcpm_pkg, pcpm_parser, pcpm_store and pcpm_out_queue.
module pixel_control_packet_merger_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  byte_in,
	input  logic [12:0] read_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        frame_dirty,
	output logic [2:0]  packet_event
);

	logic                        valid_s1;
	logic [1:0]                  mode_s1;
	logic [7:0]                  byte_s1;
	logic [pcpm_pkg::IDX_W-1:0]  idx_s1;

	logic                        valid_s2;
	logic                        sel_mem_s2;
	logic [7:0]                  hdr_s2;
	logic                        dirty_s2;
	logic [2:0]                  event_s2;

	pcpm_pkg::wr_req_t           wr;
	pcpm_pkg::rd_req_t           rd;
	logic [7:0]                  rdata;
	logic                        clearing;
	logic [2:0]                  ev_s1;
	logic                        dirty_s1;
	logic [pcpm_pkg::IDX_W-1:0]  off_s1;
	logic                        is_read_s1;
	logic [7:0]                  hdr_s1;
	pcpm_pkg::result_t           result_s2;
	pcpm_pkg::result_t           head;
	logic [pcpm_pkg::QCNT_W-1:0] q_count;
	logic [pcpm_pkg::QCNT_W:0]   inflight;
	logic                        accept;

	assign inflight = (pcpm_pkg::QCNT_W+1)'(valid_s1) + (pcpm_pkg::QCNT_W+1)'(valid_s2)
		+ (pcpm_pkg::QCNT_W+1)'(q_count);
	assign in_ready = !clearing && (inflight < (pcpm_pkg::QCNT_W+1)'(pcpm_pkg::QDEPTH));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			byte_s1 <= byte_in;
			idx_s1  <= read_index;
		end
		if (valid_s1) begin
			sel_mem_s2 <= rd.en;
			hdr_s2     <= hdr_s1;
			dirty_s2   <= dirty_s1;
			event_s2   <= ev_s1;
		end
	end

	pcpm_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (valid_s1),
		.mode         (mode_s1),
		.byte_in      (byte_s1),
		.wr           (wr),
		.packet_event (ev_s1),
		.dirty_next   (dirty_s1)
	);

	// Frame layout: two zero bytes, the 16-bit store size, then the store.
	assign is_read_s1 = valid_s1 && (pcpm_pkg::mode_t'(mode_s1) == pcpm_pkg::MODE_READ);
	assign off_s1     = idx_s1 - pcpm_pkg::IDX_W'(pcpm_pkg::HDR_BYTES);
	assign rd.en      = is_read_s1 && (idx_s1 >= pcpm_pkg::IDX_W'(pcpm_pkg::HDR_BYTES))
		&& (off_s1 < pcpm_pkg::IDX_W'(pcpm_pkg::STORE_BYTES));
	assign rd.addr    = pcpm_pkg::ADDR_W'(off_s1);

	always_comb begin
		hdr_s1 = 8'h00;
		if (is_read_s1 && (idx_s1 < pcpm_pkg::IDX_W'(pcpm_pkg::HDR_BYTES))) begin
			case (idx_s1[1:0])
				2'd2:    hdr_s1 = pcpm_pkg::FRAME_SIZE16[15:8];
				2'd3:    hdr_s1 = pcpm_pkg::FRAME_SIZE16[7:0];
				default: hdr_s1 = 8'h00;
			endcase
		end
	end

	pcpm_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd       (rd),
		.rdata    (rdata),
		.clearing (clearing)
	);

	assign result_s2.read_data    = sel_mem_s2 ? rdata : hdr_s2;
	assign result_s2.frame_dirty  = dirty_s2;
	assign result_s2.packet_event = event_s2;

	pcpm_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s2),
		.push_data (result_s2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head),
		.count     (q_count)
	);

	assign read_data    = head.read_data;
	assign frame_dirty  = head.frame_dirty;
	assign packet_event = head.packet_event;

endmodule

>>> sv/pcpm_checker.sv
// Port-level checks of the packet merger core, bound to the top level.
// Depends on pcpm_pkg and pixel_control_packet_merger_core_defines.svh.
`include "pixel_control_packet_merger_core_defines.svh"

module pcpm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  read_data,
	input logic        frame_dirty,
	input logic [2:0]  packet_event
);

	`PCPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
	`PCPM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(read_data) && $stable(packet_event), "result word changed while stalled")
	`PCPM_ASSERT_IMPLY(a_stored_dirty, out_valid && (packet_event == pcpm_pkg::EV_STORED), frame_dirty, "stored packet without dirty flag")
	`PCPM_ASSERT_IMPLY(a_event_no_data, out_valid && (packet_event != pcpm_pkg::EV_NONE), read_data == 8'h00, "stream word returned frame data")

endmodule

bind pixel_control_packet_merger_core pcpm_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.read_data    (read_data),
	.frame_dirty  (frame_dirty),
	.packet_event (packet_event)
);

>>> tb/sv/pcpm_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the pixel-control packet merger core: mirrors the packet parser, the LED
// store and the dirty flag, and checks every result word against the oldest one due.
// Depends on pcpm_pkg for sizes, codes and the result word layout.
module pcpm_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  byte_in,
	input  logic [12:0] read_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  read_data,
	input  logic        frame_dirty,
	input  logic [2:0]  packet_event,
	output int          mismatches,
	output int          words_due
);

	localparam int unsigned FRAME_LEN = pcpm_pkg::STORE_BYTES & 32'h0000_FFFF;
	localparam int REPORT_CAP = 60;

	logic [pcpm_pkg::HP_W-1:0] hdr_pos = pcpm_pkg::HP_CHAN;
	logic [7:0]  pkt_chan = 8'h00;
	logic [7:0]  pkt_cmd = 8'h00;
	logic [15:0] pkt_len = 16'h0000;
	logic [15:0] pay_pos = 16'h0000;
	logic        pkt_ok = 1'b0;
	logic        dirty = 1'b0;
	logic [7:0]  leds [pcpm_pkg::STORE_BYTES];
	int          words_seen = 0;
	pcpm_pkg::result_t result_words_due[$];

	initial begin
		mismatches = 0;
		words_due = 0;
		foreach (leds[i])
			leds[i] = 8'h00;
	end

	function automatic logic [7:0] frame_byte_at(input logic [12:0] idx);
		int unsigned pos;
		pos = idx;
		if (pos < 2)
			return 8'h00;
		if (pos == 2)
			return FRAME_LEN[15:8];
		if (pos == 3)
			return FRAME_LEN[7:0];
		pos = pos - pcpm_pkg::HDR_BYTES;
		if (pos < pcpm_pkg::STORE_BYTES)
			return leds[pos];
		return 8'h00;
	endfunction

	task automatic take_stream_byte(input logic [7:0] b, output pcpm_pkg::event_t ev);
		int unsigned addr;
		ev = pcpm_pkg::EV_NONE;
		if (hdr_pos != pcpm_pkg::HP_PAYLOAD) begin
			case (hdr_pos)
				pcpm_pkg::HP_CHAN: begin
					pkt_chan = b;
				end
				pcpm_pkg::HP_CMD: begin
					pkt_cmd = b;
				end
				pcpm_pkg::HP_LEN_HI: begin
					pkt_len = {b, 8'h00};
				end
				default: begin
					pkt_len[7:0] = b;
				end
			endcase
			hdr_pos = hdr_pos + 1'b1;
			if (hdr_pos == pcpm_pkg::HP_PAYLOAD) begin
				pay_pos = 16'h0000;
				pkt_ok = 1'b0;
				if (pkt_cmd != pcpm_pkg::CMD_SET_PIXELS)
					ev = pcpm_pkg::EV_BAD_CMD;
				else if (pkt_chan >= pcpm_pkg::CHANNELS)
					ev = pcpm_pkg::EV_BAD_CHAN;
				else if (pkt_len > pcpm_pkg::SLICE_BYTES)
					ev = pcpm_pkg::EV_BAD_LEN;
				else
					pkt_ok = 1'b1;
				if (pkt_len == 16'h0000) begin
					hdr_pos = pcpm_pkg::HP_CHAN;
					if (pkt_ok) begin
						dirty = 1'b1;
						ev = pcpm_pkg::EV_STORED;
					end
					pkt_ok = 1'b0;
				end
			end
		end else begin
			if (pkt_ok) begin
				addr = pkt_chan * pcpm_pkg::SLICE_BYTES + pay_pos;
				if (addr < pcpm_pkg::STORE_BYTES)
					leds[addr] = b;
			end
			pay_pos = pay_pos + 1'b1;
			if (pay_pos >= pkt_len) begin
				hdr_pos = pcpm_pkg::HP_CHAN;
				if (pkt_ok) begin
					dirty = 1'b1;
					ev = pcpm_pkg::EV_STORED;
				end
				pkt_ok = 1'b0;
			end
		end
	endtask

	task automatic predict_result_word(input logic [1:0] m, input logic [7:0] b,
		input logic [12:0] idx, output pcpm_pkg::result_t r);
		pcpm_pkg::event_t ev;
		ev = pcpm_pkg::EV_NONE;
		r.read_data = 8'h00;
		case (m)
			pcpm_pkg::MODE_STREAM: begin
				take_stream_byte(b, ev);
			end
			pcpm_pkg::MODE_READ: begin
				r.read_data = frame_byte_at(idx);
			end
			pcpm_pkg::MODE_CLEAR: begin
				dirty = 1'b0;
			end
			default: begin
			end
		endcase
		r.frame_dirty = dirty;
		r.packet_event = ev;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < REPORT_CAP)
			$display("%0t: result word %0d: %s is %0d, expected %0d",
				$time, words_seen, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		pcpm_pkg::result_t fresh;
		pcpm_pkg::result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_result_word(mode, byte_in, read_index, fresh);
				result_words_due.push_back(fresh);
			end
			if (out_valid && out_ready) begin
				if (result_words_due.size() == 0) begin
					report_mismatch("word with nothing due, read_data", read_data, -1);
				end else begin
					want = result_words_due.pop_front();
					if (read_data !== want.read_data)
						report_mismatch("read_data", read_data, want.read_data);
					if (frame_dirty !== want.frame_dirty)
						report_mismatch("frame_dirty", frame_dirty, want.frame_dirty);
					if (packet_event !== want.packet_event)
						report_mismatch("packet_event", packet_event, want.packet_event);
				end
				words_seen++;
			end
			words_due = result_words_due.size();
		end
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the packet merger testbench: clock, reset, the word stream and the result stall
// pattern. Depends on pcpm_pkg, pixel_control_packet_merger_core and pcpm_scoreboard.
module tb_top;

	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = pcpm_pkg::MODE_READ;
	logic [7:0]  byte_in = 8'h00;
	logic [12:0] read_index = 13'h0000;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  read_data;
	logic        frame_dirty;
	logic [2:0]  packet_event;

	int mismatches;
	int words_due;
	int words_sent = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic hold_asked = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	pixel_control_packet_merger_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.byte_in(byte_in),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.frame_dirty(frame_dirty),
		.packet_event(packet_event)
	);

	pcpm_scoreboard u_scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.byte_in(byte_in),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.frame_dirty(frame_dirty),
		.packet_event(packet_event),
		.mismatches(mismatches),
		.words_due(words_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asked && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	function automatic logic [12:0] random_index();
		if ($urandom_range(0, 1) == 0)
			return 13'($urandom_range(0, 8191));
		return 13'(pcpm_pkg::HDR_BYTES
			+ $urandom_range(0, pcpm_pkg::CHANNELS - 1) * pcpm_pkg::SLICE_BYTES
			+ $urandom_range(0, 31));
	endfunction

	task automatic send_word(input logic [1:0] m, input logic [7:0] b, input logic [12:0] idx);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		byte_in <= b;
		read_index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic side_word();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			send_word(pcpm_pkg::MODE_READ, 8'($urandom), random_index());
		else if (pick < 9)
			send_word(pcpm_pkg::MODE_CLEAR, 8'($urandom), random_index());
		else
			send_word(MODE_NOP, 8'($urandom), random_index());
	endtask

	task automatic send_packet(input logic [7:0] chan, input logic [7:0] cmd,
		input logic [15:0] len, input int mix_pct);
		logic [7:0] hdr [4];
		int unsigned k;
		hdr = '{chan, cmd, len[15:8], len[7:0]};
		for (k = 0; k < 4 + len; k++) begin
			if ($urandom_range(0, 99) < mix_pct)
				side_word();
			if (k < 4)
				send_word(pcpm_pkg::MODE_STREAM, hdr[k], random_index());
			else
				send_word(pcpm_pkg::MODE_STREAM, 8'($urandom), random_index());
		end
	endtask

	task automatic random_traffic(input int upto);
		int unsigned pick;
		int unsigned len;
		while (words_sent < upto) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 19) == 0)
				len = $urandom_range(25, 300);
			else
				len = $urandom_range(0, 24);
			if (pick < 65) begin
				send_packet(8'($urandom_range(0, pcpm_pkg::CHANNELS - 1)),
					pcpm_pkg::CMD_SET_PIXELS, 16'(len), 10);
			end else if (pick < 75) begin
				send_packet(8'($urandom_range(pcpm_pkg::CHANNELS, 255)),
					pcpm_pkg::CMD_SET_PIXELS, 16'(len), 10);
			end else if (pick < 85) begin
				send_packet(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
					16'(len), 10);
			end else begin
				repeat ($urandom_range(1, 6))
					side_word();
			end
		end
	endtask

	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 23;
		rx_idle_pct = 75;
		for (int i = 0; i < 4; i++)
			send_word(pcpm_pkg::MODE_READ, 8'h00, 13'(i));
		send_word(pcpm_pkg::MODE_READ, 8'hFF, 13'h1FFF);
		send_word(MODE_NOP, 8'hFF, 13'h1FFF);
		send_packet(8'(pcpm_pkg::CHANNELS - 1), pcpm_pkg::CMD_SET_PIXELS, 16'h0000, 0);
		send_word(pcpm_pkg::MODE_CLEAR, 8'h00, 13'h0000);
		send_packet(8'(pcpm_pkg::CHANNELS), pcpm_pkg::CMD_SET_PIXELS, 16'h0000, 0);
		send_packet(8'hFF, 8'hFF, 16'h0001, 0);
		send_packet(8'h00, pcpm_pkg::CMD_SET_PIXELS, 16'h0003, 0);
		send_word(pcpm_pkg::MODE_READ, 8'h00, 13'(pcpm_pkg::HDR_BYTES));
		random_traffic(650);

		tx_idle_pct = 75;
		rx_idle_pct = 23;
		random_traffic(1300);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_asked = 1'b1;
		send_word(pcpm_pkg::MODE_READ, 8'h00,
			13'(pcpm_pkg::HDR_BYTES + pcpm_pkg::STORE_BYTES - 1));
		send_word(pcpm_pkg::MODE_READ, 8'h00, 13'(pcpm_pkg::HDR_BYTES + pcpm_pkg::STORE_BYTES));
		random_traffic(1930);

		// The header of a packet one byte too long ends the stream.
		send_word(pcpm_pkg::MODE_STREAM, 8'h00, random_index());
		send_word(pcpm_pkg::MODE_STREAM, pcpm_pkg::CMD_SET_PIXELS, random_index());
		send_word(pcpm_pkg::MODE_STREAM, 8'((pcpm_pkg::SLICE_BYTES + 1) >> 8), random_index());
		send_word(pcpm_pkg::MODE_STREAM, 8'(pcpm_pkg::SLICE_BYTES + 1), random_index());

		in_valid <= 1'b0;
		@(negedge clk);
		while (words_due != 0)
			@(negedge clk);
		repeat (20)
			@(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/pcpm_pkg.sv
sv/pcpm_parser.sv
sv/pcpm_store.sv
sv/pcpm_out_queue.sv
sv/pixel_control_packet_merger_core.sv
sv/pcpm_checker.sv
tb/sv/pcpm_scoreboard.sv
tb/sv/tb_top.sv
